### src/ibab_pkg.sv
// ----------------------------------------------------------------------------
// ibab_pkg: shared definitions for the indexed block allocation bitmap unit
// Operation and status codes, default sizes and the controller command type.
// ----------------------------------------------------------------------------
package ibab_pkg;

  localparam int unsigned IBAB_NUM_BLOCKS      = 64;
  localparam int unsigned IBAB_MAX_FILE_BLOCKS = 63;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned BLK_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MAP_W    = 64;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN  = 2'd0,
    OP_DATA   = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INDEX_BUSY = 3'd1,
    ST_BLOCK_BUSY = 3'd2,
    ST_NO_FILE    = 3'd3,
    ST_NO_PENDING = 3'd4
  } status_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;   // Execute the request on the input ports at this edge.
  } ibab_cmd_t;

endpackage

### src/ibab_ram.sv
// ----------------------------------------------------------------------------
// ibab_ram: generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module ibab_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 126,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ibab_ctrl.sv
// ----------------------------------------------------------------------------
// ibab_ctrl: request sequencer
// Takes one request, lets the datapath execute it, then holds the response.
// ----------------------------------------------------------------------------
module ibab_ctrl
  import ibab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ibab_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.exec  = in_ready_o && in_valid_i;

  a_accept_gives_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("accepted request did not produce a response");

  a_resp_held_until_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && !cmd_o.exec))
    else $error("stalled response dropped or overlapped by a new request");

  a_one_request_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a response is still held");

endmodule

### src/ibab_dpath.sv
// ----------------------------------------------------------------------------
// ibab_dpath: allocation datapath
// Bit vector, directory, pending create and the two-bank block list.
// ----------------------------------------------------------------------------
module ibab_dpath
  import ibab_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS      = IBAB_NUM_BLOCKS,
  parameter int unsigned MAX_FILE_BLOCKS = IBAB_MAX_FILE_BLOCKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ibab_cmd_t           cmd_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [BLK_W-1:0]    index_block_i,
  input  logic [BLK_W-1:0]    block_count_i,
  input  logic [BLK_W-1:0]    block_number_i,
  input  logic [BLK_W-1:0]    dir_position_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [MAP_W-1:0]    used_map_o,
  output logic [BLK_W-1:0]    file_index_o,
  output logic [BLK_W-1:0]    file_length_o,
  output logic [BLK_W-1:0]    dir_block_o
);

  localparam int unsigned DEPTH = 2 * MAX_FILE_BLOCKS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [BLK_W-1:0] MaxBlk = BLK_W'(MAX_FILE_BLOCKS);
  localparam logic [AW-1:0]    BankOfs = AW'(MAX_FILE_BLOCKS);

  // Mask of one block; a number at or above NUM_BLOCKS yields no bit.
  function automatic logic [MAP_W-1:0] blk_bit(input logic [BLK_W-1:0] n);
    logic [MAP_W-1:0] one;
    one = MAP_W'(1);
    if ({1'b0, n} < (BLK_W + 1)'(NUM_BLOCKS)) begin
      return one << n;
    end
    return '0;
  endfunction

  logic [MAP_W-1:0]    free_map_q, free_map_d;
  logic [MAP_W-1:0]    file_mask_q, file_mask_d;
  logic [MAP_W-1:0]    pend_mask_q, pend_mask_d;
  logic                live_bank_q, live_bank_d;
  logic [BLK_W-1:0]    dir_index_q, dir_index_d;
  logic [BLK_W-1:0]    dir_count_q, dir_count_d;
  logic [BLK_W-1:0]    pend_index_q, pend_index_d;
  logic [BLK_W-1:0]    pend_total_q, pend_total_d;
  logic [BLK_W-1:0]    pend_recv_q, pend_recv_d;
  logic                pend_free_q, pend_free_d;
  logic                pend_active_q, pend_active_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                rd_hit_q, rd_hit_d;

  logic [MAP_W-1:0] idx_bit, data_bit, pend_idx_bit, pmask_new, commit_mask;
  logic             idx_busy, data_busy, free_new;
  logic [BLK_W-1:0] cnt_sat, recv_new;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [BLK_W-1:0] ram_rdata;

  assign idx_bit      = blk_bit(index_block_i);
  assign data_bit     = blk_bit(block_number_i);
  assign pend_idx_bit = blk_bit(pend_index_q);
  assign idx_busy     = (idx_bit == '0) || ((free_map_q & idx_bit) != '0);
  assign data_busy    = (data_bit == '0) || ((free_map_q & data_bit) != '0);
  assign cnt_sat      = (block_count_i > MaxBlk) ? MaxBlk : block_count_i;
  assign pmask_new    = pend_mask_q | data_bit;
  assign free_new     = pend_free_q && !data_busy;
  assign recv_new     = pend_recv_q + BLK_W'(1);
  assign commit_mask  = pend_idx_bit | pmask_new;

  // New data blocks go to the spare bank, queries read the live bank.
  assign ram_waddr = live_bank_q ? AW'(pend_recv_q) : BankOfs + AW'(pend_recv_q);
  assign ram_raddr = live_bank_q ? BankOfs + AW'(dir_position_i) : AW'(dir_position_i);

  always_comb begin
    free_map_d    = free_map_q;
    file_mask_d   = file_mask_q;
    pend_mask_d   = pend_mask_q;
    live_bank_d   = live_bank_q;
    dir_index_d   = dir_index_q;
    dir_count_d   = dir_count_q;
    pend_index_d  = pend_index_q;
    pend_total_d  = pend_total_q;
    pend_recv_d   = pend_recv_q;
    pend_free_d   = pend_free_q;
    pend_active_d = pend_active_q;
    status_d      = status_q;
    rd_hit_d      = rd_hit_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      rd_hit_d = 1'b0;
      case (operation_i)
        OP_BEGIN: begin
          // Any begin drops the create in progress.
          pend_active_d = 1'b0;
          pend_index_d  = '0;
          pend_total_d  = '0;
          pend_recv_d   = '0;
          pend_free_d   = 1'b1;
          pend_mask_d   = '0;
          if (idx_busy) begin
            status_d = ST_INDEX_BUSY;
          end else if (cnt_sat == '0) begin
            // A file without data blocks commits at once, banks untouched.
            free_map_d  = free_map_q | idx_bit;
            file_mask_d = idx_bit;
            dir_index_d = index_block_i;
            dir_count_d = '0;
          end else begin
            pend_index_d  = index_block_i;
            pend_total_d  = cnt_sat;
            pend_active_d = 1'b1;
          end
        end
        OP_DATA: begin
          if (!pend_active_q) begin
            status_d = ST_NO_PENDING;
          end else begin
            ram_we = (pend_recv_q < MaxBlk);
            if (recv_new >= pend_total_q) begin
              if (free_new) begin
                free_map_d  = free_map_q | commit_mask;
                file_mask_d = commit_mask;
                dir_index_d = pend_index_q;
                dir_count_d = pend_total_q;
                live_bank_d = !live_bank_q;
              end else begin
                status_d = ST_BLOCK_BUSY;
              end
              pend_active_d = 1'b0;
              pend_index_d  = '0;
              pend_total_d  = '0;
              pend_recv_d   = '0;
              pend_free_d   = 1'b1;
              pend_mask_d   = '0;
            end else begin
              pend_mask_d = pmask_new;
              pend_free_d = free_new;
              pend_recv_d = recv_new;
            end
          end
        end
        OP_DELETE: begin
          if (file_mask_q == '0) begin
            status_d = ST_NO_FILE;
          end else begin
            free_map_d  = free_map_q & ~file_mask_q;
            file_mask_d = '0;
            dir_index_d = '0;
            dir_count_d = '0;
          end
        end
        OP_QUERY: begin
          if (file_mask_q == '0) begin
            status_d = ST_NO_FILE;
          end else if ((dir_position_i < dir_count_q) && (dir_position_i < MaxBlk)) begin
            ram_re   = 1'b1;
            rd_hit_d = 1'b1;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q    <= '0;
      file_mask_q   <= '0;
      pend_mask_q   <= '0;
      live_bank_q   <= 1'b0;
      dir_index_q   <= '0;
      dir_count_q   <= '0;
      pend_index_q  <= '0;
      pend_total_q  <= '0;
      pend_recv_q   <= '0;
      pend_free_q   <= 1'b1;
      pend_active_q <= 1'b0;
      status_q      <= ST_OK;
      rd_hit_q      <= 1'b0;
    end else begin
      free_map_q    <= free_map_d;
      file_mask_q   <= file_mask_d;
      pend_mask_q   <= pend_mask_d;
      live_bank_q   <= live_bank_d;
      dir_index_q   <= dir_index_d;
      dir_count_q   <= dir_count_d;
      pend_index_q  <= pend_index_d;
      pend_total_q  <= pend_total_d;
      pend_recv_q   <= pend_recv_d;
      pend_free_q   <= pend_free_d;
      pend_active_q <= pend_active_d;
      status_q      <= status_d;
      rd_hit_q      <= rd_hit_d;
    end
  end

  ibab_ram #(
    .WIDTH(BLK_W),
    .DEPTH(DEPTH)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(block_number_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign status_o      = status_q;
  assign used_map_o    = free_map_q;
  assign file_index_o  = dir_index_q;
  assign file_length_o = dir_count_q;
  assign dir_block_o   = rd_hit_q ? ram_rdata : '0;

  a_file_marked_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (file_mask_q & ~free_map_q) == '0)
    else $error("directory file holds a block that is marked free");

  a_pending_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_active_q |-> ((pend_recv_q < pend_total_q) && (pend_total_q <= MaxBlk)))
    else $error("pending create counters out of range");

  a_idle_pending_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_active_q |-> ((pend_mask_q == '0) && (pend_recv_q == '0) && pend_free_q))
    else $error("pending create state left behind");

endmodule

### src/indexed_block_allocation_bitmap_unit.sv
// ----------------------------------------------------------------------------
// indexed_block_allocation_bitmap_unit: block bitmap with one indexed file
// Top level joining the request sequencer and the allocation datapath.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries
// an operation: begin create, data block, delete or query. Every request
// yields exactly one response on the output channel (out_valid_o /
// out_ready_i) with a status code, the used-block bit vector after the
// request, the directory's index block and length, and for a query the data
// block at the asked list position.
// A request accepted at one edge has its response valid in the next cycle.
// The unit holds one request at a time, so the input is ready again in the
// cycle after the response is taken, and no new request is taken before
// that. The list of data blocks sits in a registered-read RAM that is read
// at the accepting edge, like the response registers.
// A stalled response stays stable on the output ports, and no new request is
// taken until it is accepted.
// Reset clears the bit vector, the directory and any pending create. The
// list RAM is not cleared; directory lengths keep every read inside entries
// that were written. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_block_allocation_bitmap_unit
  import ibab_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS      = IBAB_NUM_BLOCKS,
  parameter int unsigned MAX_FILE_BLOCKS = IBAB_MAX_FILE_BLOCKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [BLK_W-1:0]    index_block_i,
  input  logic [BLK_W-1:0]    block_count_i,
  input  logic [BLK_W-1:0]    block_number_i,
  input  logic [BLK_W-1:0]    dir_position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [MAP_W-1:0]    used_map_o,
  output logic [BLK_W-1:0]    file_index_o,
  output logic [BLK_W-1:0]    file_length_o,
  output logic [BLK_W-1:0]    dir_block_o
);

  // The sequencer tells the datapath when a request executes.
  ibab_cmd_t cmd;

  ibab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // All state updates happen at the accepting edge; the response registers
  // and the RAM read data then hold until the response is taken.
  ibab_dpath #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .index_block_i (index_block_i),
    .block_count_i (block_count_i),
    .block_number_i(block_number_i),
    .dir_position_i(dir_position_i),
    .status_o      (status_o),
    .used_map_o    (used_map_o),
    .file_index_o  (file_index_o),
    .file_length_o (file_length_o),
    .dir_block_o   (dir_block_o)
  );

endmodule

### tb/tb_indexed_block_allocation_bitmap_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_block_allocation_bitmap_unit: self-checking bench for the unit
// A queue-fed driver offers create, data block, delete and query requests in
// random bursts. A monitor takes replies under a varying stall pattern and
// compares each one with the reply that the bench's own allocator model
// predicted when the request was accepted.
// ----------------------------------------------------------------------------
module tb_indexed_block_allocation_bitmap_unit;
  import ibab_pkg::*;

  localparam int unsigned NBLK        = IBAB_NUM_BLOCKS;
  localparam int unsigned MAXF        = IBAB_MAX_FILE_BLOCKS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_REQS = 1100;

  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] index_block;
    logic [BLK_W-1:0] block_count;
    logic [BLK_W-1:0] block_number;
    logic [BLK_W-1:0] dir_position;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAP_W-1:0]    used_map;
    logic [BLK_W-1:0]    file_index;
    logic [BLK_W-1:0]    file_length;
    logic [BLK_W-1:0]    dir_block;
  } alloc_rsp_t;

  // Clock, reset and the ports of the unit. Every input is known from time 0.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation    = '0;
  logic [BLK_W-1:0]    index_block  = '0;
  logic [BLK_W-1:0]    block_count  = '0;
  logic [BLK_W-1:0]    block_number = '0;
  logic [BLK_W-1:0]    dir_position = '0;
  logic                out_valid_o;
  logic                out_ready    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [MAP_W-1:0]    used_map_o;
  logic [BLK_W-1:0]    file_index_o;
  logic [BLK_W-1:0]    file_length_o;
  logic [BLK_W-1:0]    dir_block_o;

  indexed_block_allocation_bitmap_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation),
    .index_block_i  (index_block),
    .block_count_i  (block_count),
    .block_number_i (block_number),
    .dir_position_i (dir_position),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .used_map_o     (used_map_o),
    .file_index_o   (file_index_o),
    .file_length_o  (file_length_o),
    .dir_block_o    (dir_block_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Allocator model. It holds the used-block vector, the one-file directory,
  // the create that is collecting data blocks, and two list banks: a create
  // fills the spare bank, and only a successful commit makes it live, so a
  // failed create never disturbs the stored list.
  // --------------------------------------------------------------------------
  logic [MAP_W-1:0] used_bits;
  logic [MAP_W-1:0] file_bits;
  logic [MAP_W-1:0] gather_bits;
  logic [BLK_W-1:0] list_ram [2][MAXF];
  logic             live_half;
  logic [BLK_W-1:0] dir_idx, dir_len;
  logic [BLK_W-1:0] pend_idx, pend_len, pend_got;
  logic             pend_clean, pend_on;

  alloc_req_t       requests_to_send [$];
  alloc_rsp_t       bitmap_replies_due [$];
  alloc_req_t       cur_req;

  int               mismatch_count = 0;
  int               reply_count    = 0;
  int               random_reqs    = 0;
  int unsigned      cycle_count    = 0;

  // A block number outside the disk has no bit and so always counts as used.
  function automatic logic [MAP_W-1:0] block_mask(input logic [BLK_W-1:0] n);
    return (n < NBLK) ? (MAP_W'(1) << n) : '0;
  endfunction

  task automatic drop_create();
    pend_on     = 1'b0;
    pend_idx    = '0;
    pend_len    = '0;
    pend_got    = '0;
    pend_clean  = 1'b1;
    gather_bits = '0;
  endtask

  task automatic commit_file(input bit flip_bank);
    logic [MAP_W-1:0] m;
    m = block_mask(pend_idx) | gather_bits;
    used_bits = used_bits | m;
    file_bits = m;
    dir_idx   = pend_idx;
    dir_len   = pend_len;
    if (flip_bank) begin
      live_half = ~live_half;
    end
    drop_create();
  endtask

  task automatic clear_allocator();
    used_bits = '0;
    file_bits = '0;
    live_half = 1'b0;
    dir_idx   = '0;
    dir_len   = '0;
    for (int b = 0; b < 2; b++) begin
      for (int e = 0; e < MAXF; e++) begin
        list_ram[b][e] = '0;
      end
    end
    drop_create();
  endtask

  // Applies one accepted request to the model and returns the reply it owes.
  task automatic bitmap_apply(input alloc_req_t rq, output alloc_rsp_t rs);
    logic [MAP_W-1:0] b;
    status_e          st;
    logic [BLK_W-1:0] blk_out;
    st      = ST_OK;
    blk_out = '0;
    case (rq.op)
      OP_BEGIN: begin
        b = block_mask(rq.index_block);
        drop_create();
        if (b == '0 || (used_bits & b) != '0) begin
          st = ST_INDEX_BUSY;
        end else begin
          pend_idx = rq.index_block;
          pend_len = (rq.block_count > MAXF) ? BLK_W'(MAXF) : rq.block_count;
          if (pend_len == '0) begin
            commit_file(1'b0);
          end else begin
            pend_on = 1'b1;
          end
        end
      end
      OP_DATA: begin
        if (!pend_on) begin
          st = ST_NO_PENDING;
        end else begin
          b = block_mask(rq.block_number);
          if (pend_got < MAXF) begin
            list_ram[~live_half][pend_got] = rq.block_number;
          end
          gather_bits = gather_bits | b;
          if (b == '0 || (used_bits & b) != '0) begin
            pend_clean = 1'b0;
          end
          pend_got = pend_got + 1'b1;
          if (pend_got >= pend_len) begin
            if (pend_clean) begin
              commit_file(1'b1);
            end else begin
              st = ST_BLOCK_BUSY;
              drop_create();
            end
          end
        end
      end
      OP_DELETE: begin
        if (file_bits == '0) begin
          st = ST_NO_FILE;
        end else begin
          used_bits = used_bits & ~file_bits;
          file_bits = '0;
          dir_idx   = '0;
          dir_len   = '0;
        end
      end
      default: begin
        if (file_bits == '0) begin
          st = ST_NO_FILE;
        end else if (rq.dir_position < dir_len && rq.dir_position < MAXF) begin
          blk_out = list_ram[live_half][rq.dir_position];
        end
      end
    endcase
    rs.status      = st;
    rs.used_map    = used_bits;
    rs.file_index  = dir_idx;
    rs.file_length = dir_len;
    rs.dir_block   = blk_out;
  endtask

  // --------------------------------------------------------------------------
  // Driver. It offers requests in bursts of random length with random gaps
  // between them. A request that is on the port stays there unchanged until
  // the unit takes it; the model is updated at that edge.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_req_t nxt;
    alloc_rsp_t due;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        bitmap_apply(cur_req, due);
        bitmap_replies_due.push_back(due);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
          nxt          = requests_to_send.pop_front();
          cur_req      <= nxt;
          operation    <= nxt.op;
          index_block  <= nxt.index_block;
          block_count  <= nxt.block_count;
          block_number <= nxt.block_number;
          dir_position <= nxt.dir_position;
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            // A quarter of the bursts run straight into the next one.
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It picks a new stall style whenever the low six bits of its
  // cycle counter are zero. Twice or more in the run it holds off while the
  // driver keeps a request waiting, so the unit fills up and holds input off.
  // --------------------------------------------------------------------------
  logic [1:0]  rdy_style = 2'd0;
  int unsigned rdy_cycle = 0;
  int          hold_left = 0;
  int          hold_at   = 150;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rdy_cycle <= 0;
      hold_left <= 0;
    end else begin
      rdy_cycle <= rdy_cycle + 1;
      if (rdy_cycle[5:0] == 6'd0) begin
        rdy_style <= 2'($urandom_range(0, 3));
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (reply_count >= hold_at) begin
        hold_left <= 400;
        hold_at   <= hold_at + 450;
        out_ready <= 1'b0;
      end else begin
        case (rdy_style)
          2'd0: begin
            out_ready <= 1'b1;
          end
          2'd1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2'd2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= rdy_cycle[1];
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each reply taken is checked field by field against the oldest
  // prediction. A reply with nothing predicted is an error too.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      reply_count <= reply_count + 1;
      if (bitmap_replies_due.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("reply %0d arrived with no request outstanding", reply_count);
        end
      end else begin
        want = bitmap_replies_due.pop_front();
        if (status_o !== want.status || used_map_o !== want.used_map ||
            file_index_o !== want.file_index || file_length_o !== want.file_length ||
            dir_block_o !== want.dir_block) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("reply %0d: want st=%0d map=%h idx=%0d len=%0d blk=%0d",
                     reply_count, want.status, want.used_map, want.file_index,
                     want.file_length, want.dir_block);
            $display("reply %0d:  got st=%0d map=%h idx=%0d len=%0d blk=%0d",
                     reply_count, status_o, used_map_o, file_index_o,
                     file_length_o, dir_block_o);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("indexed_block_allocation_bitmap_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_request(input op_e op, input logic [BLK_W-1:0] ib,
                               input logic [BLK_W-1:0] cnt, input logic [BLK_W-1:0] bn,
                               input logic [BLK_W-1:0] pos);
    alloc_req_t rq;
    rq.op           = op;
    rq.index_block  = ib;
    rq.block_count  = cnt;
    rq.block_number = bn;
    rq.dir_position = pos;
    requests_to_send.push_back(rq);
    random_reqs = random_reqs + 1;
  endtask

  // Returns once every queued request has been taken, so the model state is
  // current and new requests can be shaped from it.
  task automatic wait_requests_done();
    do begin
      @(negedge clk_i);
    end while (requests_to_send.size() != 0 || in_valid);
  endtask

  // Picks a random block that is free (or used) in the model right now. If
  // there is none of the wanted kind, any block is returned.
  function automatic logic [BLK_W-1:0] pick_block(input bit want_free);
    int start;
    int n;
    start = $urandom_range(0, NBLK - 1);
    for (int k = 0; k < NBLK; k++) begin
      n = (start + k) % NBLK;
      if (used_bits[n] != want_free) begin
        return BLK_W'(n);
      end
    end
    return BLK_W'(start);
  endfunction

  function automatic logic [BLK_W-1:0] rnd_pos();
    return BLK_W'($urandom_range(0, 62));
  endfunction

  // One create sequence. Blocks of a file that is overwritten without a
  // delete stay used for good, so the old file is nearly always deleted
  // first and the disk does not silt up.
  task automatic queue_create(input bit go_clean);
    logic [BLK_W-1:0] idx;
    logic [BLK_W-1:0] cnt;
    logic [BLK_W-1:0] blk;
    int               stop_at;
    if (file_bits != '0 && ($urandom_range(0, 9) != 0 || $countones(used_bits) > 32)) begin
      queue_request(OP_DELETE, BLK_W'($urandom), BLK_W'($urandom), BLK_W'($urandom),
                    rnd_pos());
      wait_requests_done();
    end
    idx = pick_block(go_clean || $urandom_range(0, 1));
    case ($urandom_range(0, 19))
      0, 1: begin
        cnt = '0;
      end
      2: begin
        cnt = BLK_W'($urandom_range(20, 63));
      end
      default: begin
        cnt = BLK_W'($urandom_range(1, 6));
      end
    endcase
    // Now and then the sequence is cut short and left pending.
    stop_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, cnt) : cnt;
    queue_request(OP_BEGIN, idx, cnt, BLK_W'($urandom), rnd_pos());
    blk = idx;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 9) != 0) begin
        blk = pick_block(go_clean ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 2) != 0));
      end
      queue_request(OP_DATA, BLK_W'($urandom), BLK_W'($urandom), blk, rnd_pos());
      if ($urandom_range(0, 29) == 0) begin
        queue_request(OP_QUERY, BLK_W'($urandom), BLK_W'($urandom), BLK_W'($urandom),
                      rnd_pos());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Reset, directed requests, random requests and the end of the run.
  // --------------------------------------------------------------------------
  initial begin
    alloc_req_t rq;
    int         r;
    clear_allocator();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing on the disk yet: no file to delete or query, no create pending.
    queue_request(OP_QUERY, 0, 0, 0, 0);
    queue_request(OP_DELETE, 0, 0, 0, 0);
    queue_request(OP_DATA, 0, 0, 63, 0);
    // A create with no data blocks commits at once and is still a file.
    queue_request(OP_BEGIN, 0, 0, 0, 0);
    queue_request(OP_QUERY, 0, 0, 0, 0);
    queue_request(OP_DELETE, 0, 0, 0, 0);
    // Highest index; the last data block equals the index block.
    queue_request(OP_BEGIN, 63, 3, 0, 0);
    queue_request(OP_DATA, 0, 0, 0, 0);
    queue_request(OP_DATA, 0, 0, 62, 0);
    queue_request(OP_DATA, 0, 0, 63, 0);
    queue_request(OP_QUERY, 0, 0, 0, 2);
    queue_request(OP_QUERY, 0, 0, 0, 62);
    // Index already used.
    queue_request(OP_BEGIN, 63, 1, 0, 0);
    // One data block already used: the create fails and the list stays.
    queue_request(OP_BEGIN, 5, 2, 0, 0);
    queue_request(OP_DATA, 0, 0, 62, 0);
    queue_request(OP_DATA, 0, 0, 7, 0);
    // A begin drops the create in progress; the new one commits over the
    // existing file, whose blocks stay used.
    queue_request(OP_BEGIN, 20, 2, 0, 0);
    queue_request(OP_DATA, 0, 0, 21, 0);
    queue_request(OP_BEGIN, 22, 1, 0, 0);
    queue_request(OP_DATA, 0, 0, 23, 0);
    // A delete in the middle of a create frees a block that the create
    // then takes.
    queue_request(OP_BEGIN, 30, 2, 0, 0);
    queue_request(OP_DATA, 0, 0, 31, 0);
    queue_request(OP_DELETE, 0, 0, 0, 0);
    queue_request(OP_DATA, 0, 0, 22, 0);
    queue_request(OP_QUERY, 0, 0, 0, 1);

    wait_requests_done();
    random_reqs = 0;
    while (random_reqs < RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_create(1'b1);
      end else if (r < 70) begin
        queue_request(OP_QUERY, BLK_W'($urandom), BLK_W'($urandom), BLK_W'($urandom),
                      (file_bits != '0 && $urandom_range(0, 3) != 0) ?
                      BLK_W'($urandom_range(0, (dir_len < 62) ? dir_len + 1 : 62)) : rnd_pos());
      end else if (r < 78) begin
        queue_request(OP_DELETE, BLK_W'($urandom), BLK_W'($urandom), BLK_W'($urandom),
                      rnd_pos());
      end else if (r < 90) begin
        // Noise: any request with random fields. A begin over a live file
        // would strand its blocks, so it becomes a query then.
        rq = alloc_req_t'($urandom);
        if (rq.op == OP_BEGIN && file_bits != '0) begin
          rq.op = OP_QUERY;
        end
        queue_request(rq.op, rq.index_block, rq.block_count, rq.block_number, rnd_pos());
        if (rq.op == OP_DATA && !pend_on) begin
          random_reqs = random_reqs - 1;
        end
      end else if (r < 95) begin
        queue_request(OP_BEGIN, pick_block(1'b0), BLK_W'($urandom), BLK_W'($urandom),
                      rnd_pos());
      end else begin
        queue_create(1'b0);
      end
      wait_requests_done();
    end

    do begin
      @(negedge clk_i);
    end while (requests_to_send.size() != 0 || in_valid || bitmap_replies_due.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && bitmap_replies_due.size() == 0) begin
      $display("indexed_block_allocation_bitmap_unit verification clean");
    end else begin
      $display("indexed_block_allocation_bitmap_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/ibab_pkg.sv
src/ibab_ram.sv
src/ibab_ctrl.sv
src/ibab_dpath.sv
src/indexed_block_allocation_bitmap_unit.sv
tb/tb_indexed_block_allocation_bitmap_unit.sv
